/* src/ppt_pkg.sv */
// Shared constants and codes for the promotable priority table.
package ppt_pkg;

  localparam int ENTRIES        = 16;
  localparam int PAYLOAD_WIDTH  = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int IDX_W          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SEQ_W          = 32;
  localparam int KEY_W          = PRIORITY_WIDTH + SEQ_W;

  localparam int CMD_W      = 3;
  localparam int ID_W       = 4;
  localparam int PAY_PORT_W = 32;
  localparam int STATUS_W   = 2;
  localparam int PRI_PORT_W = 16;

  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PROMOTE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADID = 2'd3;

endpackage

/* src/promotable_priority_table_unit.sv */
// Every command answers through one output register stage.
// One word is in work at a time; the free-slot and maximum searches step a
// shared counter through the slot table, one slot and one key compare a cycle.
// Reset clears the slot used bits, the sequence counter and all control state;
// slot contents are not cleared and there is no clearing pass.
module promotable_priority_table_unit
  import ppt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [ID_W-1:0]       entry_id_i,
  input  logic [PAY_PORT_W-1:0] payload_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [ID_W-1:0]       id_out_o,
  output logic [PAY_PORT_W-1:0] payload_out_o,
  output logic [PRI_PORT_W-1:0] priority_out_o,
  output logic                  is_valid_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_READ,
    S_ACCESS,
    S_SCAN,
    S_SCAN_END,
    S_SEL,
    S_NOP
  } state_e;

  localparam logic [IDX_W-1:0]          LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [PRIORITY_WIDTH-1:0] PRI_MAX  = {PRIORITY_WIDTH{1'b1}};

  state_e state_q;
  logic [IDX_W-1:0]         cnt_q;
  logic [CMD_W-1:0]         cmd_q;
  logic [ID_W-1:0]          id_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  logic [ENTRIES-1:0]       used_q;
  logic [SEQ_W-1:0]         next_seq_q;

  logic [PRIORITY_WIDTH-1:0] mem_pri [ENTRIES];
  logic [PAYLOAD_WIDTH-1:0]  mem_pay [ENTRIES];
  logic [SEQ_W-1:0]          mem_seq [ENTRIES];

  logic [PRIORITY_WIDTH-1:0] rd_pri_q;
  logic [PAYLOAD_WIDTH-1:0]  rd_pay_q;
  logic [SEQ_W-1:0]          rd_seq_q;
  logic                      rd_used_q;
  logic [IDX_W-1:0]          rd_idx_q;
  logic                      sv_q;

  logic                     best_found_q;
  logic [KEY_W-1:0]         best_key_q;
  logic [PAYLOAD_WIDTH-1:0] best_pay_q;
  logic [IDX_W-1:0]         best_idx_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [ID_W-1:0]       id_out_q;
  logic [PAY_PORT_W-1:0] pay_out_q;
  logic [PRI_PORT_W-1:0] pri_out_q;
  logic                  is_valid_q;

  logic                  in_fire;
  logic                  can_emit;
  logic                  emit;
  logic                  emitting;
  logic [STATUS_W-1:0]   res_status;
  logic [ID_W-1:0]       res_id;
  logic [PAY_PORT_W-1:0] res_pay;
  logic [PRI_PORT_W-1:0] res_pri;
  logic                  res_valid;

  logic [IDX_W-1:0]          id_idx;
  logic                      id_ok;
  logic                      free_here;
  logic [IDX_W-1:0]          rd_addr;
  logic [PRIORITY_WIDTH-1:0] pri_inc;
  logic [KEY_W-1:0]          rd_key;
  logic                      take;

  logic                      we_all;
  logic                      we_pri;
  logic [IDX_W-1:0]          waddr;
  logic [PRIORITY_WIDTH-1:0] wpri;
  logic                      set_used;
  logic                      clr_used;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign can_emit   = !out_valid_q || out_ready_i;
  assign emit       = emitting && can_emit;

  assign id_idx    = IDX_W'(id_q);
  assign id_ok     = (32'(id_q) < 32'(ENTRIES)) && used_q[id_idx];
  assign free_here = !used_q[cnt_q];
  assign rd_addr   = (state_q == S_SCAN) ? cnt_q : id_idx;
  assign pri_inc   = (rd_pri_q == PRI_MAX) ? rd_pri_q : rd_pri_q + 1'b1;
  assign rd_key    = {rd_pri_q, rd_seq_q};
  assign take      = sv_q && rd_used_q && (!best_found_q || (rd_key > best_key_q));

  always_comb begin
    emitting   = 1'b0;
    res_status = ST_OK;
    res_id     = '0;
    res_pay    = '0;
    res_pri    = '0;
    res_valid  = 1'b0;
    we_all     = 1'b0;
    we_pri     = 1'b0;
    waddr      = cnt_q;
    wpri       = '0;
    set_used   = 1'b0;
    clr_used   = 1'b0;
    case (state_q)
      S_FREE: begin
        if (free_here) begin
          emitting = 1'b1;
          res_id   = ID_W'(cnt_q);
          res_pay  = PAY_PORT_W'(pay_q);
          we_all   = can_emit;
          set_used = can_emit;
        end else if (cnt_q == LAST_IDX) begin
          emitting   = 1'b1;
          res_status = ST_FULL;
        end
      end
      S_ACCESS: begin
        emitting = 1'b1;
        res_id   = id_q;
        if (!id_ok) begin
          res_status = ST_BADID;
        end else if (cmd_q == CMD_PROMOTE) begin
          res_pay = PAY_PORT_W'(rd_pay_q);
          res_pri = PRI_PORT_W'(pri_inc);
          we_pri  = can_emit;
          waddr   = id_idx;
          wpri    = pri_inc;
        end else begin
          res_pay   = PAY_PORT_W'(rd_pay_q);
          res_pri   = PRI_PORT_W'(rd_pri_q);
          res_valid = 1'b1;
        end
      end
      S_SEL: begin
        emitting = 1'b1;
        if (best_found_q) begin
          res_id   = ID_W'(best_idx_q);
          res_pay  = PAY_PORT_W'(best_pay_q);
          res_pri  = PRI_PORT_W'(best_key_q[KEY_W-1:SEQ_W]);
          clr_used = can_emit && (cmd_q == CMD_POP);
        end else begin
          res_status = ST_EMPTY;
        end
      end
      S_NOP: begin
        emitting = 1'b1;
      end
      default: begin
        emitting = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_all) begin
      mem_pri[waddr] <= '0;
      mem_pay[waddr] <= pay_q;
      mem_seq[waddr] <= next_seq_q;
    end else if (we_pri) begin
      mem_pri[waddr] <= wpri;
    end
    rd_pri_q <= mem_pri[rd_addr];
    rd_pay_q <= mem_pay[rd_addr];
    rd_seq_q <= mem_seq[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      cmd_q        <= '0;
      id_q         <= '0;
      pay_q        <= '0;
      used_q       <= '0;
      next_seq_q   <= '0;
      rd_used_q    <= 1'b0;
      rd_idx_q     <= '0;
      sv_q         <= 1'b0;
      best_found_q <= 1'b0;
      best_key_q   <= '0;
      best_pay_q   <= '0;
      best_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= '0;
      id_out_q     <= '0;
      pay_out_q    <= '0;
      pri_out_q    <= '0;
      is_valid_q   <= 1'b0;
    end else begin
      rd_used_q <= used_q[rd_addr];
      rd_idx_q  <= rd_addr;
      sv_q      <= (state_q == S_SCAN);
      if (take) begin
        best_found_q <= 1'b1;
        best_key_q   <= rd_key;
        best_pay_q   <= rd_pay_q;
        best_idx_q   <= rd_idx_q;
      end
      if (set_used) begin
        used_q[cnt_q] <= 1'b1;
        next_seq_q    <= next_seq_q + 1'b1;
      end
      if (clr_used) begin
        used_q[best_idx_q] <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        status_q    <= res_status;
        id_out_q    <= res_id;
        pay_out_q   <= res_pay;
        pri_out_q   <= res_pri;
        is_valid_q  <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q        <= cmd_i;
            id_q         <= entry_id_i;
            pay_q        <= PAYLOAD_WIDTH'(payload_i);
            cnt_q        <= '0;
            best_found_q <= 1'b0;
            case (cmd_i)
              CMD_ADD:     state_q <= S_FREE;
              CMD_PROMOTE: state_q <= S_READ;
              CMD_QUERY:   state_q <= S_READ;
              CMD_PEEK:    state_q <= S_SCAN;
              CMD_POP:     state_q <= S_SCAN;
              default:     state_q <= S_NOP;
            endcase
          end
        end
        S_FREE: begin
          if (emit) begin
            state_q <= S_IDLE;
          end else if (!emitting) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_READ: begin
          state_q <= S_ACCESS;
        end
        S_SCAN: begin
          if (cnt_q == LAST_IDX) begin
            state_q <= S_SCAN_END;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SCAN_END: begin
          state_q <= S_SEL;
        end
        S_ACCESS, S_SEL, S_NOP: begin
          if (emit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign id_out_o       = id_out_q;
  assign payload_out_o  = pay_out_q;
  assign priority_out_o = pri_out_q;
  assign is_valid_o     = is_valid_q;

`ifndef SYNTHESIS
  a_pop_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEL && emit && cmd_q == CMD_POP && best_found_q)
      |=> !used_q[$past(best_idx_q)])
    else $error("pop did not free the selected slot");

  a_add_claims_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE && emit && free_here)
      |=> (used_q[$past(cnt_q)] && next_seq_q == $past(next_seq_q) + 1'b1))
    else $error("add did not claim its slot and advance the sequence");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res_status == ST_FULL) |-> (&used_q))
    else $error("table full reported with a free slot");
`endif

endmodule

/* verif/promotable_priority_table_unit_test.sv */
// Self-checking testbench for the promotable priority table unit.
module promotable_priority_table_unit_test;
  import ppt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 2 * (ENTRIES + 4);
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_WORDS  = 420;
  localparam int REPORT_LIMIT  = 10;
  localparam int RAISE_STEPS   = 8;

  localparam int MIX_FILL     = 0;
  localparam int MIX_DRAIN    = 1;
  localparam int MIX_BALANCED = 2;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       id;
    logic [PAY_PORT_W-1:0] payload;
    logic [PRI_PORT_W-1:0] prio;
    logic                  is_valid;
  } table_reply_t;

  class table_scoreboard;
    bit                        busy[ENTRIES];
    logic [PRIORITY_WIDTH-1:0] prio_of[ENTRIES];
    logic [PAYLOAD_WIDTH-1:0]  data_of[ENTRIES];
    logic [SEQ_W-1:0]          age_of[ENTRIES];
    logic [SEQ_W-1:0]          age_next;
    table_reply_t              expected_replies[$];
    int unsigned accepted   = 0;
    int unsigned checked    = 0;
    int unsigned mismatches = 0;
    int unsigned full_hits  = 0;
    int unsigned empty_hits = 0;
    int unsigned bad_ids    = 0;
    int unsigned saturated  = 0;

    function new();
      foreach (busy[i]) busy[i] = 1'b0;
      age_next = '0;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (busy[i]) if (busy[i]) n++;
      return n;
    endfunction

    function logic [ID_W-1:0] live_slot();
      int picks[$];
      int slot;
      foreach (busy[i]) if (busy[i]) picks.insert(picks.size(), i);
      if (picks.size() == 0) slot = $urandom_range(0, ENTRIES - 1);
      else slot = picks[$urandom_range(0, picks.size() - 1)];
      return slot[ID_W-1:0];
    endfunction

    function int strongest_slot();
      int best;
      best = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (busy[i] && (best < 0 || prio_of[i] > prio_of[best] ||
            (prio_of[i] == prio_of[best] && age_of[i] > age_of[best]))) begin
          best = i;
        end
      end
      return best;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [PAY_PORT_W-1:0] pay);
      table_reply_t r;
      int slot;
      r.status   = ST_OK;
      r.id       = '0;
      r.payload  = '0;
      r.prio     = '0;
      r.is_valid = 1'b0;
      slot = -1;
      accepted++;
      case (cmd)
        CMD_ADD: begin
          for (int i = 0; i < ENTRIES && slot < 0; i++) begin
            if (!busy[i]) slot = i;
          end
          if (slot < 0) begin
            r.status = ST_FULL;
            full_hits++;
          end else begin
            busy[slot]    = 1'b1;
            data_of[slot] = pay[PAYLOAD_WIDTH-1:0];
            prio_of[slot] = '0;
            age_of[slot]  = age_next;
            age_next      = age_next + 1'b1;
            r.id      = slot[ID_W-1:0];
            r.payload = data_of[slot];
          end
        end
        CMD_PROMOTE, CMD_QUERY: begin
          r.id = id;
          if (!busy[id]) begin
            r.status = ST_BADID;
            bad_ids++;
          end else begin
            if (cmd == CMD_PROMOTE) begin
              if (&prio_of[id]) saturated++;
              else prio_of[id] = prio_of[id] + 1'b1;
            end else begin
              r.is_valid = 1'b1;
            end
            r.payload = data_of[id];
            r.prio    = prio_of[id];
          end
        end
        CMD_PEEK, CMD_POP: begin
          slot = strongest_slot();
          if (slot < 0) begin
            r.status = ST_EMPTY;
            empty_hits++;
          end else begin
            r.id      = slot[ID_W-1:0];
            r.payload = data_of[slot];
            r.prio    = prio_of[slot];
            if (cmd == CMD_POP) busy[slot] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      expected_replies.insert(expected_replies.size(), r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
                              logic [PAY_PORT_W-1:0] pay, logic [PRI_PORT_W-1:0] pri,
                              logic vld);
      table_reply_t want;
      checked++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Reply %0d arrived with none pending: status=%0d id=%0d payload=%h prio=%0d valid=%0d",
                   checked, st, id, pay, pri, vld);
        end
        return;
      end
      want = expected_replies.pop_front();
      if (st !== want.status || id !== want.id || pay !== want.payload ||
          pri !== want.prio || vld !== want.is_valid) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Reply %0d differs: expected status=%0d id=%0d payload=%h prio=%0d valid=%0d",
                   checked, want.status, want.id, want.payload, want.prio, want.is_valid);
          $display("  actual status=%0d id=%0d payload=%h prio=%0d valid=%0d",
                   st, id, pay, pri, vld);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      cmd_i = '0;
  logic [ID_W-1:0]       entry_id_i = '0;
  logic [PAY_PORT_W-1:0] payload_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [ID_W-1:0]       id_out_o;
  logic [PAY_PORT_W-1:0] payload_out_o;
  logic [PRI_PORT_W-1:0] priority_out_o;
  logic                  is_valid_o;

  bit          sender_idling = 1'b1;
  bit          receiver_idling = 1'b1;
  int unsigned cycle_count = 0;
  table_scoreboard book;

  promotable_priority_table_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .entry_id_i     (entry_id_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .id_out_o       (id_out_o),
    .payload_out_o  (payload_out_o),
    .priority_out_o (priority_out_o),
    .is_valid_o     (is_valid_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      book.check_reply(status_o, id_out_o, payload_out_o, priority_out_o, is_valid_o);
    end
  end

  initial begin
    int unsigned span;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (receiver_idling && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        span = $urandom_range(1, 10);
      end else begin
        out_ready_i <= 1'b1;
        span = $urandom_range(1, 20);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [PAY_PORT_W-1:0] pay);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    entry_id_i <= id;
    payload_i  <= pay;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_command(cmd, id, pay);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (book.expected_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input int words, input int mix);
    int pick;
    int add_cut;
    int promote_cut;
    int peek_cut;
    int pop_cut;
    logic [CMD_W-1:0]      cmd;
    logic [ID_W-1:0]       id;
    logic [PAY_PORT_W-1:0] pay;
    case (mix)
      MIX_FILL: begin
        add_cut = 55; promote_cut = 75; peek_cut = 80; pop_cut = 85;
      end
      MIX_DRAIN: begin
        add_cut = 10; promote_cut = 30; peek_cut = 40; pop_cut = 85;
      end
      default: begin
        add_cut = 30; promote_cut = 55; peek_cut = 65; pop_cut = 80;
      end
    endcase
    repeat (words) begin
      pick = $urandom_range(0, 99);
      if (pick < add_cut) cmd = CMD_ADD;
      else if (pick < promote_cut) cmd = CMD_PROMOTE;
      else if (pick < peek_cut) cmd = CMD_PEEK;
      else if (pick < pop_cut) cmd = CMD_POP;
      else if (pick < 96) cmd = CMD_QUERY;
      else cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      if ((cmd == CMD_PROMOTE || cmd == CMD_QUERY) && $urandom_range(0, 4) != 0) begin
        id = book.live_slot();
      end else begin
        id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
      end
      case ($urandom_range(0, 19))
        0:       pay = '0;
        1:       pay = '1;
        default: pay = $urandom;
      endcase
      send_word(cmd, id, pay);
    end
  endtask

  initial begin
    int words_left;
    int span;
    bit paused_once;
    book = new();
    paused_once = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_PEEK, '0, '0);
    send_word(CMD_POP, '0, '0);
    send_word(CMD_QUERY, '0, '0);
    send_word(CMD_PROMOTE, '1, '0);
    send_word(CMD_SPARE_FIRST, '1, '1);
    send_word(CMD_SPARE_LAST, '1, '1);
    send_word(CMD_ADD, '0, '0);
    send_word(CMD_ADD, '1, '1);
    send_word(CMD_ADD, '0, 32'hA5A5_A5A5);
    send_word(CMD_PEEK, '0, '0);
    send_word(CMD_PROMOTE, 4'd1, '0);
    send_word(CMD_PEEK, '0, '0);
    send_word(CMD_QUERY, 4'd1, '0);
    send_word(CMD_POP, '0, '0);
    send_word(CMD_QUERY, 4'd1, '0);
    send_word(CMD_ADD, '0, 32'h5A5A_5A5A);
    while (book.occupancy() < ENTRIES) send_word(CMD_ADD, '0, $urandom);
    send_word(CMD_ADD, '0, $urandom);

    // Hold off until the table has answered everything sent so far.
    wait_quiet();

    // Raise one entry a few steps above the rest of the full table.
    sender_idling = 1'b0;
    receiver_idling = 1'b0;
    repeat (RAISE_STEPS) send_word(CMD_PROMOTE, 4'd5, '0);
    send_word(CMD_PEEK, '0, '0);
    send_word(CMD_QUERY, 4'd5, '0);
    wait_quiet();

    words_left = RANDOM_WORDS;
    while (words_left > 60) begin
      span = $urandom_range(30, 60);
      sender_idling = ($urandom_range(0, 3) != 0);
      receiver_idling = ($urandom_range(0, 3) != 0);
      random_phase(span, $urandom_range(MIX_FILL, MIX_BALANCED));
      words_left -= span;
      if (!paused_once && words_left < RANDOM_WORDS / 2) begin
        wait_quiet();
        paused_once = 1'b1;
      end
    end
    sender_idling = 1'b0;
    receiver_idling = 1'b0;
    random_phase(words_left, MIX_BALANCED);
    wait_quiet();

    $display("Run covered %0d commands and %0d replies; full table seen %0d times, empty %0d times.",
             book.accepted, book.checked, book.full_hits, book.empty_hits);
    $display("Bad ids rejected %0d times, promotes held at top priority %0d times, %0d mismatches.",
             book.bad_ids, book.saturated, book.mismatches);
    if (book.mismatches == 0 && book.expected_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
